// ===== rtl/msaec_pkg.sv =====
// package for the sensor angle ellipse correction block
// holds the cordic arctangent table, register indexes and datapath widths
`timescale 1ns / 1ps
package msaec_pkg;

  localparam int TABLE_LEN = 24;
  localparam int DW        = 40;   // cordic datapath width, covers all growth
  localparam int REG_W     = 16;
  localparam int INV_GAIN  = 9949;

  localparam logic [1:0] REG_ANGLE_OFS    = 2'd0;
  localparam logic [1:0] REG_ELLIPSE_GAIN = 2'd1;
  localparam logic [1:0] REG_CENTER_X     = 2'd2;
  localparam logic [1:0] REG_CENTER_Y     = 2'd3;

  typedef logic signed [DW-1:0] dw_t;

  typedef struct packed {
    logic signed [11:0] angle_ofs;
    logic [15:0]        ellipse_gain;
    logic signed [15:0] ctr_x;
    logic signed [15:0] ctr_y;
  } cfg_t;

  function automatic logic [31:0] atan_entry(input int i);
    logic [31:0] tab [TABLE_LEN];
    tab = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
            32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
            32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
            32'd166886, 32'd83443, 32'd41722, 32'd20861,
            32'd10430, 32'd5215, 32'd2608, 32'd1304,
            32'd652, 32'd326, 32'd163, 32'd81};
    return tab[i];
  endfunction

endpackage

// ===== rtl/mr_sensor_angle_ellipse_correction.sv =====
// Angle offset and ellipse correction for a magnetoresistive angle sensor.
// Input channel in_valid/in_stall carries raw_angle; output channel
// out_valid/out_stall carries corrected_angle. Config writes go through
// cfg_we/cfg_index/cfg_data and take effect at once; write them only when
// the pipeline is empty.
// The datapath is fully pipelined: one register for the offset add and
// quadrant fold, min(CORDIC_STEPS, TABLE_LEN) rotation stages, one register
// for the quadrant unfold, one for the gain multiply, one for the centre
// offsets and sign fold, as many vectoring stages and the output register.
// Throughput is one item per cycle while no stalled result holds the
// pipeline, set by the unrolled cordic stages.
// When out_stall is high with a result waiting, the whole pipeline holds
// and in_stall rises; nothing is lost or repeated. Bubbles are not squeezed
// out, so in_stall follows a blocked output even while earlier stages are
// empty.
// Synchronous reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
module mr_sensor_angle_ellipse_correction
  import msaec_pkg::*;
#(
  parameter int ANGLE_BITS   = 12,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ANGLE_BITS-1:0] raw_angle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ANGLE_BITS-1:0] corrected_angle,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  localparam int N = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  cfg_t cfg;
  logic en;

  msaec_cfg_regs u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg
  );

  // simple global enable: hold everything while a result waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 0: offset add and quadrant fold
  logic [ANGLE_BITS-1:0] a_sum;
  logic [31:0] phase, r;
  logic [1:0]  q;
  logic        v0;
  logic [31:0] z0;
  logic [1:0]  q0;

  always_comb begin
    a_sum = raw_angle + ANGLE_BITS'(cfg.angle_ofs);
    phase = {a_sum, {(32-ANGLE_BITS){1'b0}}};
    q     = 2'((phase + 32'h2000_0000) >> 30);
    r     = phase - {q, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      z0 <= r;
      q0 <= q;
    end
  end

  logic        rv [N+1];
  dw_t         rx [N+1];
  dw_t         ry [N+1];
  logic [31:0] rz [N+1];
  logic [1:0]  rq [N+1];

  assign rv[0] = v0;
  assign rx[0] = DW'(INV_GAIN);
  assign ry[0] = '0;
  assign rz[0] = z0;
  assign rq[0] = q0;

  for (genvar i = 0; i < N; i++) begin : g_rot
    msaec_cordic_stage #(.STEP(i), .VECTORING(1'b0), .SIDE_W(2)) u_st (
      .clk, .rst, .en,
      .in_valid(rv[i]), .in_x(rx[i]), .in_y(ry[i]), .in_z(rz[i]), .in_side(rq[i]),
      .out_valid(rv[i+1]), .out_x(rx[i+1]), .out_y(ry[i+1]), .out_z(rz[i+1]),
      .out_side(rq[i+1])
    );
  end

  // quadrant unfold then gain multiply
  dw_t c_sel, s_sel;
  always_comb begin
    case (rq[N])
      2'd1:    begin c_sel = -ry[N]; s_sel = rx[N];  end
      2'd2:    begin c_sel = -rx[N]; s_sel = -ry[N]; end
      2'd3:    begin c_sel = ry[N];  s_sel = -rx[N]; end
      default: begin c_sel = rx[N];  s_sel = ry[N];  end
    endcase
  end

  logic               v1;
  logic signed [20:0] c1;
  logic signed [15:0] s1g;
  dw_t                s1;
  logic signed [37:0] prod;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= rv[N];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1  <= c_sel[20:0];
      s1  <= s_sel;
      s1g <= cfg.ellipse_gain;
    end
  end

  logic signed [16:0] gain_s;
  assign gain_s = {1'b0, s1g};

  logic        v2;
  dw_t         x2, y2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 38'(c1 * gain_s);
      y2   <= s1 + DW'(cfg.ctr_y);
    end
  end

  // centre offsets and half-plane fold
  dw_t xs, xf, yf;
  logic zero_pt;
  always_comb begin
    xs      = DW'(prod >>> 14) + DW'(cfg.ctr_x);
    zero_pt = (xs == '0) && (y2 == '0);
    xf      = xs[DW-1] ? -xs : xs;
    yf      = xs[DW-1] ? -y2 : y2;
  end

  logic        vv [N+1];
  dw_t         vx [N+1];
  dw_t         vy [N+1];
  logic [31:0] vz [N+1];
  logic        vzp [N+1];

  logic        v3;
  dw_t         x3, y3;
  logic [31:0] z3;
  logic        zp3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x3  <= xf;
      y3  <= yf;
      z3  <= xs[DW-1] ? 32'h8000_0000 : 32'd0;
      zp3 <= zero_pt;
    end
  end
  assign vv[0]  = v3;
  assign vx[0]  = x3;
  assign vy[0]  = y3;
  assign vz[0]  = z3;
  assign vzp[0] = zp3;
  assign x2 = xs;

  for (genvar i = 0; i < N; i++) begin : g_vec
    msaec_cordic_stage #(.STEP(i), .VECTORING(1'b1), .SIDE_W(1)) u_st (
      .clk, .rst, .en,
      .in_valid(vv[i]), .in_x(vx[i]), .in_y(vy[i]), .in_z(vz[i]), .in_side(vzp[i]),
      .out_valid(vv[i+1]), .out_x(vx[i+1]), .out_y(vy[i+1]), .out_z(vz[i+1]),
      .out_side(vzp[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vv[N];
  end
  always_ff @(posedge clk) begin
    if (en) corrected_angle <= vzp[N] ? '0 : vz[N][31 -: ANGLE_BITS];
  end

  logic unused_ok;
  assign unused_ok = ^{x2, vx[N], vy[N], rz[N]};

endmodule

// ===== rtl/msaec_cordic_stage.sv =====
// one registered cordic micro-rotation, rotation or vectoring mode
// depends on msaec_pkg for the arctangent table and datapath type
`timescale 1ns / 1ps
module msaec_cordic_stage
  import msaec_pkg::*;
#(
  parameter int STEP = 0,
  parameter bit VECTORING = 1'b0,
  parameter int SIDE_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  dw_t               in_x,
  input  dw_t               in_y,
  input  logic [31:0]       in_z,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output dw_t               out_x,
  output dw_t               out_y,
  output logic [31:0]       out_z,
  output logic [SIDE_W-1:0] out_side
);

  logic up;
  dw_t  dx, dy;

  always_comb begin
    dx = in_y >>> STEP;
    dy = in_x >>> STEP;
    // rotation follows sign of residual angle, vectoring drives y to zero
    if (VECTORING) up = (in_y > 0);
    else up = ~in_z[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= in_side;
      if (VECTORING) begin
        out_x <= up ? in_x + dx : in_x - dx;
        out_y <= up ? in_y - dy : in_y + dy;
        out_z <= up ? in_z + atan_entry(STEP) : in_z - atan_entry(STEP);
      end else begin
        out_x <= up ? in_x - dx : in_x + dx;
        out_y <= up ? in_y + dy : in_y - dy;
        out_z <= up ? in_z - atan_entry(STEP) : in_z + atan_entry(STEP);
      end
    end
  end

endmodule

// ===== rtl/msaec_cfg_regs.sv =====
// configuration register file for offset, gain and centre registers
// depends on msaec_pkg for register indexes and cfg_t
`timescale 1ns / 1ps
module msaec_cfg_regs
  import msaec_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [REG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_ofs    <= '0;
      cfg.ellipse_gain <= 16'd16384;
      cfg.ctr_x        <= '0;
      cfg.ctr_y        <= '0;
    end else if (cfg_we && !cfg_index[2]) begin
      unique case (cfg_index[1:0])
        REG_ANGLE_OFS:    cfg.angle_ofs    <= cfg_data[11:0];
        REG_ELLIPSE_GAIN: cfg.ellipse_gain <= cfg_data;
        REG_CENTER_X:     cfg.ctr_x        <= cfg_data;
        REG_CENTER_Y:     cfg.ctr_y        <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/msaec_checker.sv =====
// port-level checker for the angle correction block
// bound to mr_sensor_angle_ellipse_correction, uses no internal signals
`timescale 1ns / 1ps
module msaec_checker #(
  parameter int ANGLE_BITS = 12
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [ANGLE_BITS-1:0] corrected_angle
);

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(corrected_angle)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_free_when_taken: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

endmodule

bind mr_sensor_angle_ellipse_correction msaec_checker #(.ANGLE_BITS(ANGLE_BITS)) u_chk (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .corrected_angle
);
